>>> sv/zrhp_pkg.sv
// ZIP record header parser: shared types, result codes and header field layout.
// Used by zrhp_step, zrhp_outq and zip_record_header_parser; no dependencies.
`timescale 1ns / 1ps

package zrhp_pkg;

  localparam logic [31:0] LOCAL_SIG   = 32'h04034B50;
  localparam logic [31:0] CENTRAL_SIG = 32'h02014B50;

  localparam logic [3:0] LAST_FIELD_LOCAL   = 4'd9;
  localparam logic [3:0] LAST_FIELD_CENTRAL = 4'd15;

  // Byte span of each fixed field, counted from the first signature byte.
  // Unused entries have an empty span and never match.
  localparam logic [5:0] FIELD_START [2][16] = '{
    '{6'd4, 6'd6, 6'd8, 6'd10, 6'd12, 6'd14, 6'd18, 6'd22, 6'd26, 6'd28,
      6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0},
    '{6'd4, 6'd6, 6'd8, 6'd10, 6'd12, 6'd14, 6'd16, 6'd20, 6'd24, 6'd28,
      6'd30, 6'd32, 6'd34, 6'd36, 6'd38, 6'd42}
  };
  localparam logic [5:0] FIELD_END [2][16] = '{
    '{6'd6, 6'd8, 6'd10, 6'd12, 6'd14, 6'd18, 6'd22, 6'd26, 6'd28, 6'd30,
      6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0},
    '{6'd6, 6'd8, 6'd10, 6'd12, 6'd14, 6'd16, 6'd20, 6'd24, 6'd28, 6'd30,
      6'd32, 6'd34, 6'd36, 6'd38, 6'd42, 6'd46}
  };

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HDR  = 2'd1,
    PH_NAME = 2'd2,
    PH_SKIP = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_FIELD = 2'd0,
    KIND_NAME  = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_SIG   = 2'd1,
    ERR_TRUNC = 2'd2
  } err_e;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  field_index;
    logic [31:0] field_value;
    logic [7:0]  name_byte;
    err_e        error_code;
    logic        last_of_run;
  } res_t;

  // Up to two results per input byte
  typedef struct packed {
    logic [1:0] count;
    res_t       r1;
    res_t       r0;
  } step_res_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
    logic [1:0] lane;
    logic       last;
  } field_hit_t;

  // Locate header byte position p within the fixed fields of record kind k.
  function automatic field_hit_t field_lookup(logic k, logic [5:0] p);
    field_hit_t h;
    logic [5:0] ofs;
    h = '0;
    for (int f = 0; f < 16; f++) begin
      if (p >= FIELD_START[k][4'(f)] && p < FIELD_END[k][4'(f)]) begin
        ofs    = p - FIELD_START[k][4'(f)];
        h.hit  = 1'b1;
        h.idx  = 4'(f);
        h.lane = ofs[1:0];
        h.last = ((p + 6'd1) == FIELD_END[k][4'(f)]);
      end
    end
    return h;
  endfunction

  function automatic res_t make_res(kind_e kind, logic [3:0] idx, logic [31:0] val,
                                    logic [7:0] nb, err_e err);
    res_t r;
    r.kind        = kind;
    r.field_index = idx;
    r.field_value = val;
    r.name_byte   = nb;
    r.error_code  = err;
    r.last_of_run = 1'b0;
    return r;
  endfunction

endpackage

>>> sv/zip_record_header_parser.sv
// ZIP record header parser, top level: stream ports, parse stage, result queue.
// Depends on zrhp_pkg, zrhp_step and zrhp_outq.
//
//   channel  dir  width  contents
//   s_axis   in   8/3    record bytes; tuser = record start, mode, end of stream
//   m_axis   out  48/2   field values, name bytes, completion and errors
//
// One byte is taken per cycle while s_axis_tready_o is high. Its results (none, one or
// two) are written to a four-entry queue in the same cycle and leave at one per cycle
// while m_axis_tready_i is high; the two results of one byte leave one after the other.
// s_axis_tready_o drops when the queue has room for fewer than two results. Reset
// (rst_ni low) returns the parser to idle and empties the queue.
`timescale 1ns / 1ps

module zip_record_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic [2:0]  s_axis_tuser_i,   // [0] record_start, [1] mode, [2] end_of_stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [3:0] field_index, [35:4] field_value,
                                        // [43:36] name_byte, [45:44] error_code, rest 0
  output logic [1:0]  m_axis_tuser_o,   // [1:0] result_kind
  output logic        m_axis_tlast_o    // last_of_run
);

  logic                in_fire;
  zrhp_pkg::step_res_t step_res;
  zrhp_pkg::res_t      head;

  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  zrhp_step u_step (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (in_fire),
    .data_byte_i     (s_axis_tdata_i),
    .record_start_i  (s_axis_tuser_i[0]),
    .mode_i          (s_axis_tuser_i[1]),
    .end_of_stream_i (s_axis_tuser_i[2]),
    .res_o           (step_res)
  );

  zrhp_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_fire),
    .res_i   (step_res),
    .room_o  (s_axis_tready_o),
    .valid_o (m_axis_tvalid_o),
    .pop_i   (m_axis_tready_i),
    .head_o  (head)
  );

  assign m_axis_tdata_o = {2'b00, head.error_code, head.name_byte, head.field_value,
                           head.field_index};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.last_of_run;

  // A pair of results is always a field or name byte followed by completion
  a_pair_ends_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && step_res.count == 2'd2) |-> (step_res.r1.kind == zrhp_pkg::KIND_DONE))
    else $error("second result of a byte is not a completion");

  // End of stream yields at most one result
  a_eos_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tuser_i[2]) |-> (step_res.count <= 2'd1))
    else $error("end of stream produced more than one result");

  // Backpressure on the input only while results are waiting
  a_stall_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with empty result queue");

endmodule

>>> sv/zrhp_step.sv
// ZIP record header parser: parse state registers and the per-byte update.
// Depends on zrhp_pkg.
`timescale 1ns / 1ps

module zrhp_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          data_byte_i,
  input  logic                record_start_i,
  input  logic                mode_i,
  input  logic                end_of_stream_i,
  output zrhp_pkg::step_res_t res_o
);

  zrhp_pkg::phase_e phase_q, phase_d;
  logic        kind_q, kind_d;
  logic [5:0]  hidx_q, hidx_d;
  logic [31:0] acc_q, acc_d;
  logic [15:0] name_rem_q, name_rem_d;
  logic [15:0] extra_len_q, extra_len_d;
  logic [16:0] skip_rem_q, skip_rem_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= zrhp_pkg::PH_IDLE;
      kind_q      <= 1'b0;
      hidx_q      <= '0;
      acc_q       <= '0;
      name_rem_q  <= '0;
      extra_len_q <= '0;
      skip_rem_q  <= '0;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      kind_q      <= kind_d;
      hidx_q      <= hidx_d;
      acc_q       <= acc_d;
      name_rem_q  <= name_rem_d;
      extra_len_q <= extra_len_d;
      skip_rem_q  <= skip_rem_d;
    end
  end

  always_comb begin
    zrhp_pkg::res_t       rs [2];
    logic [1:0]           n;
    logic                 active;
    logic                 after_name;
    logic [1:0]           lane;
    logic [31:0]          acc_or;
    zrhp_pkg::field_hit_t fh;
    logic [3:0]           last_f;

    rs[0]       = '0;
    rs[1]       = '0;
    n           = 2'd0;
    active      = 1'b1;
    after_name  = 1'b0;
    phase_d     = phase_q;
    kind_d      = kind_q;
    hidx_d      = hidx_q;
    acc_d       = acc_q;
    name_rem_d  = name_rem_q;
    extra_len_d = extra_len_q;
    skip_rem_d  = skip_rem_q;

    if (end_of_stream_i) begin
      active = 1'b0;
      if (phase_q != zrhp_pkg::PH_IDLE) begin
        rs[0]   = zrhp_pkg::make_res(zrhp_pkg::KIND_ERROR, 4'd0, 32'd0, 8'd0,
                                     zrhp_pkg::ERR_TRUNC);
        n       = 2'd1;
        phase_d = zrhp_pkg::PH_IDLE;
        hidx_d  = '0;
        acc_d   = '0;
      end
    end else if (record_start_i) begin
      if (phase_q != zrhp_pkg::PH_IDLE) begin
        rs[0] = zrhp_pkg::make_res(zrhp_pkg::KIND_ERROR, 4'd0, 32'd0, 8'd0,
                                   zrhp_pkg::ERR_TRUNC);
        n     = 2'd1;
      end
      kind_d      = mode_i;
      phase_d     = zrhp_pkg::PH_HDR;
      hidx_d      = '0;
      acc_d       = '0;
      name_rem_d  = '0;
      extra_len_d = '0;
      skip_rem_d  = '0;
    end else if (phase_q == zrhp_pkg::PH_IDLE) begin
      active = 1'b0;
    end

    fh     = zrhp_pkg::field_lookup(kind_d, hidx_d);
    last_f = kind_d ? zrhp_pkg::LAST_FIELD_CENTRAL : zrhp_pkg::LAST_FIELD_LOCAL;
    lane   = (hidx_d < 6'd4) ? hidx_d[1:0] : fh.lane;
    acc_or = acc_d | ({24'd0, data_byte_i} << {lane, 3'b000});

    if (active) begin
      case (phase_d)
        zrhp_pkg::PH_HDR: begin
          if (hidx_d < 6'd3) begin
            acc_d  = acc_or;
            hidx_d = hidx_d + 6'd1;
          end else if (hidx_d == 6'd3) begin
            if (acc_or != (kind_d ? zrhp_pkg::CENTRAL_SIG : zrhp_pkg::LOCAL_SIG)) begin
              rs[n[0]] = zrhp_pkg::make_res(zrhp_pkg::KIND_ERROR, 4'd0, 32'd0, 8'd0,
                                            zrhp_pkg::ERR_SIG);
              n        = n + 2'd1;
              phase_d  = zrhp_pkg::PH_IDLE;
              hidx_d   = '0;
              acc_d    = '0;
            end else begin
              acc_d  = '0;
              hidx_d = 6'd4;
            end
          end else if (!fh.hit) begin
            phase_d = zrhp_pkg::PH_IDLE;
            hidx_d  = '0;
            acc_d   = '0;
          end else begin
            acc_d  = acc_or;
            hidx_d = hidx_d + 6'd1;
            if (fh.last) begin
              rs[n[0]] = zrhp_pkg::make_res(zrhp_pkg::KIND_FIELD, fh.idx, acc_or, 8'd0,
                                            zrhp_pkg::ERR_NONE);
              n        = n + 2'd1;
              if (!kind_d) begin
                if (fh.idx == 4'd8) name_rem_d = acc_or[15:0];
                if (fh.idx == 4'd9) begin
                  extra_len_d = acc_or[15:0];
                  skip_rem_d  = {1'b0, acc_or[15:0]};
                end
              end else begin
                if (fh.idx == 4'd9)  name_rem_d  = acc_or[15:0];
                if (fh.idx == 4'd10) extra_len_d = acc_or[15:0];
                if (fh.idx == 4'd11) begin
                  skip_rem_d = {1'b0, extra_len_d} + {1'b0, acc_or[15:0]};
                end
              end
              acc_d = '0;
              if (fh.idx == last_f) after_name = 1'b1;
            end
          end
        end
        zrhp_pkg::PH_NAME: begin
          rs[n[0]] = zrhp_pkg::make_res(zrhp_pkg::KIND_NAME, 4'd0, 32'd0, data_byte_i,
                                        zrhp_pkg::ERR_NONE);
          n        = n + 2'd1;
          if (name_rem_d != '0) name_rem_d = name_rem_d - 16'd1;
          if (name_rem_d == '0) after_name = 1'b1;
        end
        zrhp_pkg::PH_SKIP: begin
          if (skip_rem_d != '0) skip_rem_d = skip_rem_d - 17'd1;
          if (skip_rem_d == '0) after_name = 1'b1;
        end
        default: begin
          phase_d = zrhp_pkg::PH_IDLE;
          hidx_d  = '0;
          acc_d   = '0;
        end
      endcase
    end

    // Name pass-through, then skip, then completion
    if (after_name) begin
      if (name_rem_d != '0) begin
        phase_d = zrhp_pkg::PH_NAME;
      end else if (skip_rem_d != '0) begin
        phase_d = zrhp_pkg::PH_SKIP;
      end else begin
        rs[n[0]] = zrhp_pkg::make_res(zrhp_pkg::KIND_DONE, 4'd0, 32'd0, 8'd0,
                                      zrhp_pkg::ERR_NONE);
        n        = n + 2'd1;
        phase_d  = zrhp_pkg::PH_IDLE;
        hidx_d   = '0;
        acc_d    = '0;
      end
    end

    if (n == 2'd1) rs[0].last_of_run = 1'b1;
    if (n == 2'd2) rs[1].last_of_run = 1'b1;

    res_o.count = n;
    res_o.r0    = rs[0];
    res_o.r1    = rs[1];
  end

endmodule

>>> sv/zrhp_outq.sv
// ZIP record header parser: result queue, up to two writes and one read per cycle.
// Depends on zrhp_pkg.
`timescale 1ns / 1ps

module zrhp_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  zrhp_pkg::step_res_t res_i,
  output logic                room_o,
  output logic                valid_o,
  input  logic                pop_i,
  output zrhp_pkg::res_t      head_o
);

  localparam int unsigned PtrW = $clog2(zrhp_pkg::QUEUE_DEPTH);

  zrhp_pkg::res_t  mem_q [zrhp_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;
  logic [1:0]      n_wr;
  logic            do_pop;

  assign n_wr    = push_i ? res_i.count : 2'd0;
  assign do_pop  = pop_i && (count_q != '0);
  assign wr_ptr_d = wr_ptr_q + PtrW'(n_wr);
  assign rd_ptr_d = rd_ptr_q + PtrW'(do_pop);
  assign count_d  = count_q + (PtrW+1)'(n_wr) - (PtrW+1)'(do_pop);

  // Keep room for a full pair of results
  assign room_o  = (count_q <= (PtrW+1)'(zrhp_pkg::QUEUE_DEPTH - 2));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_wr != 2'd0) mem_q[wr_ptr_q] <= res_i.r0;
    if (n_wr == 2'd2) mem_q[wr_ptr_q + PtrW'(1)] <= res_i.r1;
  end

endmodule
